@@ rtl/skt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH_DEF    = 256;
  localparam int KEY_BITS_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int SHIFT_W  = 32;
  localparam int LEN_W    = 31;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 9;
  localparam int TGT_W    = 33;

  localparam logic [CMD_W-1:0] CMD_LB    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LT    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_EXACT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INS   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ROT   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MOD,
    S_MOD_FIX,
    S_LB_CHK,
    S_LB_RD,
    S_LB_CMP,
    S_EX_RD,
    S_EX_CMP,
    S_DEL_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_INS_CHK,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_ROT_RD,
    S_ROT_WR,
    S_CP_RD,
    S_CP_WR,
    S_DONE
  } skt_state_t;

endpackage

@@ rtl/skt_mod_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_mod_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module skt_mod_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [skt_pkg::SHIFT_W-1:0] dividend,
  input  logic [skt_pkg::LEN_W-1:0]   divisor,
  output logic                        done,
  output logic [skt_pkg::LEN_W-1:0]   remainder
);
  import skt_pkg::*;

  localparam int CNT_W = $clog2(SHIFT_W + 1);

  logic               active_r, active_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SHIFT_W-1:0] a_r, a_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [LEN_W-1:0]   div_r, div_nxt;
  logic [LEN_W:0]     trial;

  assign trial = {rem_r, a_r[SHIFT_W-1]};

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    a_nxt      = a_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = CNT_W'(SHIFT_W);
      a_nxt      = dividend;
      rem_nxt    = '0;
      div_nxt    = divisor;
    end else if (active_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = LEN_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[LEN_W-1:0];
      end
      a_nxt   = {a_r[SHIFT_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
    a_r   <= a_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

@@ rtl/sorted_key_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table
// Ascending key table in a circular store, searched by bisection with one
// registered-read memory port and one shared compare/add path.
// Searches bisect the table; exact search then reads and compares the found entry.
// Insert and delete move one entry per read/write step; rotate runs the modulo
// and, unless the shift is zero, a search and two rewrite passes via scratch.
// One transfer in flight at a time; the result register frees the input side.
// Reset (synchronous, rst_n low) empties the table and zeroes the start
// pointer; store contents are left as they are.
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int DEPTH    = skt_pkg::DEPTH_DEF,
  parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [skt_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [skt_pkg::SHIFT_W-1:0]  in_key,
  input  logic [skt_pkg::LEN_W-1:0]           in_loop_length,
  input  logic                                in_append_hint,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [skt_pkg::INDEX_W-1:0]  out_index,
  output logic                                out_found,
  output logic [skt_pkg::STATUS_W-1:0]        out_status,
  output logic [skt_pkg::TOTAL_W-1:0]         out_entry_total
);
  import skt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] i);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(i);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  logic [KEY_BITS-1:0] key_store [DEPTH];
  logic [KEY_BITS-1:0] scratch   [DEPTH];

  skt_state_t state_r, state_nxt;

  logic [CMD_W-1:0]          cmd_r, cmd_nxt;
  logic signed [TGT_W-1:0]   target_r, target_nxt;
  logic [CW-1:0]             lo_r, lo_nxt, hi_r, hi_nxt, j_r, j_nxt, n_r, n_nxt;
  logic [AW-1:0]             start_r, start_nxt;
  logic [LEN_W-1:0]          s_r, s_nxt, len_r, len_nxt;
  logic                      neg_r, neg_nxt;
  logic [INDEX_W-1:0]        res_index_r, res_index_nxt;
  logic                      res_found_r, res_found_nxt;
  logic [STATUS_W-1:0]       res_status_r, res_status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]        out_index_r, out_index_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [TOTAL_W-1:0]        out_total_r, out_total_nxt;

  logic                ks_we, sc_we;
  logic [AW-1:0]       ks_waddr, ks_raddr, sc_waddr, sc_raddr;
  logic [KEY_BITS-1:0] ks_wdata, sc_wdata, ks_rd_r, sc_rd_r;

  logic                     mod_start, mod_done;
  logic [LEN_W-1:0]         mod_rem, mod_s;
  logic [SHIFT_W-1:0]       key_mag;
  logic signed [TGT_W-1:0]  in_target, rd_ext;
  logic [CW-1:0]            mid;
  logic [CW:0]              mid_sum;
  logic                     in_take, out_free, key_lt, j_last, rot_move;
  logic [SHIFT_W-1:0]       addend;
  logic [CW-1:0]            dest;

  assign in_ready  = (state_r == S_IDLE);
  assign in_take   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign key_mag   = in_key[SHIFT_W-1] ? (~in_key + SHIFT_W'(1)) : in_key;
  assign in_target = {{(TGT_W-KEY_BITS){in_key[KEY_BITS-1]}}, in_key[KEY_BITS-1:0]};
  assign rd_ext    = {{(TGT_W-KEY_BITS){ks_rd_r[KEY_BITS-1]}}, ks_rd_r};
  assign key_lt    = rd_ext < target_r;
  assign mid_sum   = (CW+1)'(lo_r) + (CW+1)'(hi_r);
  assign mid       = CW'(mid_sum >> 1);
  assign mod_s     = (neg_r && mod_rem != '0) ? (len_r - mod_rem) : mod_rem;
  assign j_last    = ((CW+1)'(j_r) + (CW+1)'(1)) == (CW+1)'(n_r);
  assign addend    = (j_r < lo_r) ? {1'b0, s_r} : ({1'b0, s_r} - {1'b0, len_r});
  assign rot_move  = (lo_r != '0) && (lo_r < n_r) && (n_r != CW'(DEPTH));
  assign dest      = !rot_move ? j_r : ((j_r >= lo_r) ? (j_r - lo_r) : (j_r + n_r - lo_r));

  skt_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (key_mag),
    .divisor   (in_loop_length),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          unique case (in_cmd)
            CMD_LB, CMD_LT, CMD_EXACT, CMD_DEL: state_nxt = S_LB_CHK;
            CMD_INS: begin
              if (n_r == CW'(DEPTH)) state_nxt = S_DONE;
              else if (in_append_hint) state_nxt = S_INS_CHK;
              else state_nxt = S_LB_CHK;
            end
            CMD_ROT: begin
              if (n_r == '0 || in_loop_length == '0) state_nxt = S_DONE;
              else state_nxt = S_MOD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_MOD:     if (mod_done) state_nxt = S_MOD_FIX;
      S_MOD_FIX: state_nxt = (mod_s == '0) ? S_DONE : S_LB_CHK;
      S_LB_CHK: begin
        if (lo_r != hi_r) begin
          state_nxt = S_LB_RD;
        end else begin
          unique case (cmd_r)
            CMD_EXACT, CMD_DEL: state_nxt = (lo_r < n_r) ? S_EX_RD : S_DONE;
            CMD_INS:            state_nxt = S_INS_CHK;
            CMD_ROT:            state_nxt = S_ROT_RD;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      S_LB_RD:   state_nxt = S_LB_CMP;
      S_LB_CMP:  state_nxt = S_LB_CHK;
      S_EX_RD:   state_nxt = S_EX_CMP;
      S_EX_CMP: begin
        if (ks_rd_r == target_r[KEY_BITS-1:0] && cmd_r == CMD_DEL) state_nxt = S_DEL_CHK;
        else state_nxt = S_DONE;
      end
      S_DEL_CHK: state_nxt = (((CW+1)'(j_r) + (CW+1)'(1)) < (CW+1)'(n_r)) ? S_DEL_RD : S_DONE;
      S_DEL_RD:  state_nxt = S_DEL_WR;
      S_DEL_WR:  state_nxt = S_DEL_CHK;
      S_INS_CHK: state_nxt = (j_r > lo_r) ? S_INS_RD : S_INS_PUT;
      S_INS_RD:  state_nxt = S_INS_WR;
      S_INS_WR:  state_nxt = S_INS_CHK;
      S_INS_PUT: state_nxt = S_DONE;
      S_ROT_RD:  state_nxt = S_ROT_WR;
      S_ROT_WR:  state_nxt = j_last ? S_CP_RD : S_ROT_RD;
      S_CP_RD:   state_nxt = S_CP_WR;
      S_CP_WR:   state_nxt = j_last ? S_DONE : S_CP_RD;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    target_nxt     = target_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    j_nxt          = j_r;
    n_nxt          = n_r;
    start_nxt      = start_r;
    s_nxt          = s_r;
    len_nxt        = len_r;
    neg_nxt        = neg_r;
    res_index_nxt  = res_index_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_index_nxt  = out_index_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_total_nxt  = out_total_r;
    mod_start      = 1'b0;
    ks_we          = 1'b0;
    ks_waddr       = '0;
    ks_wdata       = ks_rd_r;
    ks_raddr       = '0;
    sc_we          = 1'b0;
    sc_waddr       = '0;
    sc_wdata       = KEY_BITS'(ks_rd_r + addend[KEY_BITS-1:0]);
    sc_raddr       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          cmd_nxt        = in_cmd;
          target_nxt     = in_target;
          lo_nxt         = '0;
          hi_nxt         = n_r;
          j_nxt          = n_r;
          len_nxt        = in_loop_length;
          neg_nxt        = in_key[SHIFT_W-1];
          res_index_nxt  = '1;
          res_found_nxt  = 1'b0;
          res_status_nxt = ST_OK;
          unique case (in_cmd)
            CMD_INS: begin
              if (n_r == CW'(DEPTH)) res_status_nxt = ST_FULL;
              else if (in_append_hint) lo_nxt = n_r;
            end
            CMD_ROT: begin
              res_index_nxt = '0;
              if (n_r != '0 && in_loop_length != '0) mod_start = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_MOD_FIX: begin
        s_nxt      = mod_s;
        target_nxt = {2'b00, len_r - mod_s};
      end
      S_LB_CHK: begin
        if (lo_r == hi_r) begin
          unique case (cmd_r)
            CMD_LB:             res_index_nxt = INDEX_W'(lo_r);
            CMD_LT:             res_index_nxt = INDEX_W'(lo_r) - INDEX_W'(1);
            CMD_EXACT, CMD_DEL: if (lo_r >= n_r) res_status_nxt = ST_NOTFOUND;
            CMD_ROT: begin
              res_index_nxt = INDEX_W'(lo_r);
              j_nxt         = '0;
            end
            default: ;
          endcase
        end
      end
      S_LB_RD: ks_raddr = slot(start_r, mid);
      S_LB_CMP: begin
        if (key_lt) lo_nxt = mid + CW'(1);
        else hi_nxt = mid;
      end
      S_EX_RD: ks_raddr = slot(start_r, lo_r);
      S_EX_CMP: begin
        if (ks_rd_r == target_r[KEY_BITS-1:0]) begin
          res_found_nxt = 1'b1;
          res_index_nxt = INDEX_W'(lo_r);
          j_nxt         = lo_r;
        end else begin
          res_status_nxt = ST_NOTFOUND;
        end
      end
      S_DEL_CHK: begin
        if (!(((CW+1)'(j_r) + (CW+1)'(1)) < (CW+1)'(n_r))) n_nxt = n_r - CW'(1);
      end
      S_DEL_RD: ks_raddr = slot(start_r, j_r + CW'(1));
      S_DEL_WR: begin
        ks_we    = 1'b1;
        ks_waddr = slot(start_r, j_r);
        j_nxt    = j_r + CW'(1);
      end
      S_INS_RD: ks_raddr = slot(start_r, j_r - CW'(1));
      S_INS_WR: begin
        ks_we    = 1'b1;
        ks_waddr = slot(start_r, j_r);
        j_nxt    = j_r - CW'(1);
      end
      S_INS_PUT: begin
        ks_we         = 1'b1;
        ks_waddr      = slot(start_r, lo_r);
        ks_wdata      = target_r[KEY_BITS-1:0];
        n_nxt         = n_r + CW'(1);
        res_index_nxt = INDEX_W'(lo_r);
      end
      S_ROT_RD: ks_raddr = slot(start_r, j_r);
      S_ROT_WR: begin
        sc_we    = 1'b1;
        sc_waddr = AW'(dest);
        j_nxt    = j_last ? '0 : (j_r + CW'(1));
      end
      S_CP_RD: sc_raddr = AW'(j_r);
      S_CP_WR: begin
        ks_we    = 1'b1;
        ks_waddr = slot(start_r, j_r);
        ks_wdata = sc_rd_r;
        j_nxt    = j_r + CW'(1);
        if (j_last && lo_r != '0 && lo_r < n_r && n_r == CW'(DEPTH)) begin
          start_nxt = slot(start_r, lo_r);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_index_nxt  = res_index_r;
          out_found_nxt  = res_found_r;
          out_status_nxt = res_status_r;
          out_total_nxt  = TOTAL_W'(n_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ks_we) begin
      key_store[ks_waddr] <= ks_wdata;
    end
    ks_rd_r <= key_store[ks_raddr];
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      scratch[sc_waddr] <= sc_wdata;
    end
    sc_rd_r <= scratch[sc_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    target_r     <= target_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    j_r          <= j_nxt;
    s_r          <= s_nxt;
    len_r        <= len_nxt;
    neg_r        <= neg_nxt;
    res_index_r  <= res_index_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_index_r  <= out_index_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_index       = out_index_r;
  assign out_found       = out_found_r;
  assign out_status      = out_status_r;
  assign out_entry_total = out_total_r;

endmodule
